[src/tts_pkg.sv]
// Package for the task table scheduler: command codes, task states, sizes.
// Used by the channel interfaces and by every module in src.
package tts_pkg;
	localparam int NumTasksDef = 16;
	localparam int NumSemsDef = 16;
	localparam int TidW = 4;
	localparam int LinkW = 5;
	localparam logic [LinkW-1:0] LinkNull = 5'd16;

	typedef enum logic [3:0] {
		CMD_SCHED = 4'd0, CMD_CREATE = 4'd1, CMD_END = 4'd2, CMD_EXIT = 4'd3,
		CMD_WAIT = 4'd4, CMD_SGET = 4'd5, CMD_SFREE = 4'd6, CMD_P = 4'd7,
		CMD_V = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NEW = 3'd0, ST_RUNNING = 3'd1, ST_READY = 3'd2, ST_BLOCKED = 3'd3,
		ST_END = 3'd4
	} tstate_t;

	typedef struct packed {
		logic [3:0] command;
		logic [3:0] sem_index;
		logic signed [15:0] init_count;
	} req_t;

	typedef struct packed {
		logic status;
		logic [3:0] result_id;
		logic [3:0] running_task;
		logic [4:0] live_tasks;
	} rsp_t;

	typedef enum logic [3:0] {
		FS_IDLE, FS_DISPATCH, FS_SCAN, FS_SCAN_CHK, FS_WR_PAR, FS_SEM_RD,
		FS_SEM_OP, FS_V_LINK, FS_SCHED, FS_SCHED_CHK, FS_OUT
	} fsm_t;
endpackage

[src/tts_req_if.sv]
// Request channel: valid/ready handshake carrying one kernel command.
// Depends on tts_pkg.
interface tts_req_if;
	logic valid;
	logic ready;
	tts_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/tts_rsp_if.sv]
// Response channel: valid/ready handshake carrying one command result.
// Depends on tts_pkg.
interface tts_rsp_if;
	logic valid;
	logic ready;
	tts_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/task_table_scheduler_with_semaphores.sv]
// Top level of the task table scheduler with counting semaphores.
// Depends on tts_pkg, tts_req_if and tts_rsp_if.
//
// One request on req carries a kernel command; exactly one result follows on
// rsp. The task table (state, parent, wait link) sits in synchronous
// memories with a registered read port and is walked by a sequencer that
// reads each entry and then checks it. Semaphore values and wait-list heads
// sit in a second memory. A free, or a command rejected at dispatch, goes
// straight to the result; create and wait scan the table, and a wait that
// blocks then runs a schedule scan. One request is handled at a time.
// Per-entry valid bits stand in for table contents after reset, so no
// clearing pass is needed. Reset returns the kernel slot to RUNNING and
// current. While rsp is stalled the result is held in its register and a
// new request is accepted only after it is taken.
module task_table_scheduler_with_semaphores #(
	parameter int NUM_TASKS = tts_pkg::NumTasksDef,
	parameter int NUM_SEMS = tts_pkg::NumSemsDef
) (
	input logic clk,
	input logic arst_n,
	tts_req_if.sink req,
	tts_rsp_if.source rsp
);
	localparam logic [3:0] Kern = 4'(NUM_TASKS - 1);
	localparam logic [3:0] LastSem = 4'(NUM_SEMS - 1);

	logic [2:0] st_mem [NUM_TASKS];
	logic [3:0] par_mem [NUM_TASKS];
	logic [4:0] lnk_mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] tval_q;
	logic [15:0] sv_mem [NUM_SEMS];
	logic [4:0] sh_mem [NUM_SEMS];
	logic [NUM_SEMS-1:0] shval_q;
	logic [NUM_SEMS-1:0] inuse_q;

	tts_pkg::fsm_t fsm_q, fsm_d;
	tts_pkg::req_t rq_q;
	logic [3:0] cur_q, idx_q, cnt_q, scur_q, hit_q;
	logic [4:0] live_q;
	logic status_q;
	logic [3:0] rid_q;
	logic rvalid_q;
	tts_pkg::rsp_t rdata_q;

	// Task memory read port, registered.
	logic [3:0] ra;
	logic [2:0] rst_raw;
	logic [3:0] rpar_raw;
	logic [4:0] rlnk_raw;
	logic rval_q;
	logic [2:0] rst;
	logic [3:0] rpar;
	logic [4:0] rlnk;
	logic [3:0] ra_q;
	// Task memory write port.
	logic twe, twpar, twlnk;
	logic [3:0] wa;
	logic [2:0] wst;
	logic [3:0] wpar;
	logic [4:0] wlnk;
	// Semaphore read.
	logic [15:0] sv_rd;
	logic [4:0] sh_raw;
	logic shv_rd;
	logic swe, swh;
	logic [15:0] swv;
	logic [4:0] swhd;
	logic sget_wr;

	// Semaphore get writes the init value in FS_SEM_RD.
	assign sget_wr = (fsm_q == tts_pkg::FS_SEM_RD) && (rq_q.command == tts_pkg::CMD_SGET);

	always_ff @(posedge clk) begin
		if (twe) st_mem[wa] <= wst;
		if (twpar) par_mem[wa] <= wpar;
		if (twlnk) lnk_mem[wa] <= wlnk;
		rst_raw <= st_mem[ra];
		rpar_raw <= par_mem[ra];
		rlnk_raw <= lnk_mem[ra];
		if (swe) sv_mem[rq_q.sem_index] <= swv;
		else if (sget_wr) sv_mem[rid_q] <= rq_q.init_count;
		if (swh) sh_mem[rq_q.sem_index] <= swhd;
		sv_rd <= sv_mem[rq_q.sem_index];
		sh_raw <= sh_mem[rq_q.sem_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tval_q <= '0;
			shval_q <= '0;
			rval_q <= 1'b0;
			ra_q <= '0;
			shv_rd <= 1'b0;
		end else begin
			if (twe) tval_q[wa] <= 1'b1;
			if (swh) shval_q[rq_q.sem_index] <= 1'b1;
			rval_q <= tval_q[ra];
			ra_q <= ra;
			shv_rd <= shval_q[rq_q.sem_index];
		end
	end

	// Entries never written read as their reset values. Parent and link are
	// always written together with state, so one valid bit covers all three.
	always_comb begin
		rst = rval_q ? rst_raw : ((ra_q == Kern) ? tts_pkg::ST_RUNNING : tts_pkg::ST_NEW);
		rpar = rval_q ? rpar_raw : ((ra_q == Kern) ? Kern : 4'd0);
		rlnk = rval_q ? rlnk_raw : tts_pkg::LinkNull;
	end

	logic [3:0] idx_nx;
	logic [4:0] live_dec, live_inc;
	logic signed [15:0] sval, snew;
	logic [4:0] shead;
	logic sem_ok;

	always_comb begin
		idx_nx = (idx_q == Kern) ? 4'd0 : idx_q + 4'd1;
		live_dec = (live_q != 5'd0) ? live_q - 5'd1 : live_q;
		live_inc = (live_q != 5'd31) ? live_q + 5'd1 : live_q;
		sval = sv_rd;
		shead = shv_rd ? sh_raw : tts_pkg::LinkNull;
		sem_ok = rq_q.sem_index <= LastSem;
		if (rq_q.command == tts_pkg::CMD_P)
			snew = (sval != 16'sh8000) ? sval - 16'sd1 : sval;
		else
			snew = (sval != 16'sh7fff) ? sval + 16'sd1 : sval;
	end

	logic [3:0] cur_d, idx_d, cnt_d, scur_d, hit_d;
	logic [4:0] live_d;
	logic status_d;
	logic [3:0] rid_d;
	logic [NUM_SEMS-1:0] inuse_d;
	logic [3:0] free_sem;
	logic free_found;

	always_comb begin
		free_found = 1'b0;
		free_sem = '0;
		for (int k = NUM_SEMS - 1; k >= 0; k--) begin
			if (!inuse_q[k]) begin
				free_found = 1'b1;
				free_sem = 4'(k);
			end
		end
	end

	always_comb begin
		fsm_d = fsm_q;
		cur_d = cur_q;
		idx_d = idx_q;
		cnt_d = cnt_q;
		scur_d = scur_q;
		hit_d = hit_q;
		live_d = live_q;
		status_d = status_q;
		rid_d = rid_q;
		inuse_d = inuse_q;
		ra = idx_q;
		twe = 1'b0;
		twpar = 1'b0;
		twlnk = 1'b0;
		wa = cur_q;
		wst = tts_pkg::ST_NEW;
		wpar = '0;
		wlnk = '0;
		swe = 1'b0;
		swh = 1'b0;
		swv = snew;
		swhd = '0;
		case (fsm_q)
			tts_pkg::FS_IDLE: begin
				if (req.valid && !rvalid_q) begin
					fsm_d = tts_pkg::FS_DISPATCH;
					status_d = 1'b0;
					rid_d = '0;
				end
			end
			tts_pkg::FS_DISPATCH: begin
				fsm_d = tts_pkg::FS_OUT;
				case (rq_q.command)
					tts_pkg::CMD_SCHED: begin
						fsm_d = tts_pkg::FS_SCHED;
					end
					tts_pkg::CMD_CREATE, tts_pkg::CMD_WAIT: begin
						idx_d = '0;
						ra = '0;
						cnt_d = '0;
						hit_d = '0;
						fsm_d = tts_pkg::FS_SCAN;
					end
					tts_pkg::CMD_END: begin
						live_d = live_dec;
						twe = 1'b1;
						wa = cur_q;
						wst = tts_pkg::ST_END;
						twpar = 1'b1;
						twlnk = 1'b1;
						ra = cur_q;
						fsm_d = tts_pkg::FS_WR_PAR;
					end
					tts_pkg::CMD_EXIT: begin
						ra = cur_q;
						idx_d = cur_q;
						cnt_d = '0;
						fsm_d = tts_pkg::FS_SCAN;
					end
					tts_pkg::CMD_SGET: begin
						if (free_found) begin
							inuse_d[free_sem] = 1'b1;
							rid_d = free_sem;
							fsm_d = tts_pkg::FS_SEM_RD;
						end else begin
							status_d = 1'b1;
						end
					end
					tts_pkg::CMD_SFREE: begin
						if (sem_ok) inuse_d[rq_q.sem_index] = 1'b0;
						else status_d = 1'b1;
					end
					tts_pkg::CMD_P, tts_pkg::CMD_V: begin
						if (sem_ok) fsm_d = tts_pkg::FS_SEM_RD;
						else status_d = 1'b1;
					end
					default: status_d = 1'b1;
				endcase
			end
			tts_pkg::FS_WR_PAR: begin
				// End: rewrite parent and link that the state write clobbered.
				ra = cur_q;
				twpar = 1'b1;
				twlnk = 1'b1;
				wa = cur_q;
				wpar = rpar;
				wlnk = rlnk;
				fsm_d = tts_pkg::FS_OUT;
				if (1'b1) begin
					twe = 1'b1;
					wst = tts_pkg::ST_END;
				end
			end
			tts_pkg::FS_SCAN: begin
				// One table entry is being read; check it next cycle.
				ra = idx_q;
				fsm_d = tts_pkg::FS_SCAN_CHK;
			end
			tts_pkg::FS_SCAN_CHK: begin
				ra = idx_q;
				case (rq_q.command)
					tts_pkg::CMD_CREATE: begin
						if (rst == tts_pkg::ST_NEW) begin
							twe = 1'b1;
							twpar = 1'b1;
							twlnk = 1'b1;
							wa = idx_q;
							wst = tts_pkg::ST_READY;
							wpar = idx_q;
							wlnk = rlnk;
							live_d = live_inc;
							rid_d = idx_q;
							fsm_d = tts_pkg::FS_OUT;
						end else if (idx_q == Kern) begin
							status_d = 1'b1;
							fsm_d = tts_pkg::FS_OUT;
						end else begin
							idx_d = idx_nx;
							fsm_d = tts_pkg::FS_SCAN;
						end
					end
					tts_pkg::CMD_WAIT: begin
						if (rst != tts_pkg::ST_NEW && rpar == cur_q && idx_q != cur_q) begin
							hit_d = 4'd1;
						end
						if (idx_q == Kern) begin
							if (hit_d != 4'd0 || (rst != tts_pkg::ST_NEW && rpar == cur_q
									&& idx_q != cur_q)) begin
								idx_d = cur_q;
								hit_d = 4'd0;
								fsm_d = tts_pkg::FS_V_LINK;
							end else begin
								status_d = 1'b1;
								fsm_d = tts_pkg::FS_OUT;
							end
						end else begin
							idx_d = idx_nx;
							fsm_d = tts_pkg::FS_SCAN;
						end
					end
					default: begin
						// Exit: cnt_q 0 reads current entry, 1 reads parent.
						if (cnt_q == 4'd0) begin
							hit_d = rpar;
							idx_d = rpar;
							cnt_d = 4'd1;
							twe = 1'b1;
							twpar = 1'b1;
							twlnk = 1'b1;
							wa = cur_q;
							wst = tts_pkg::ST_NEW;
							wpar = rpar;
							wlnk = rlnk;
							live_d = live_dec;
							fsm_d = tts_pkg::FS_SCAN;
						end else begin
							if (rst == tts_pkg::ST_BLOCKED) begin
								twe = 1'b1;
								twpar = 1'b1;
								twlnk = 1'b1;
								wa = idx_q;
								wst = tts_pkg::ST_READY;
								wpar = rpar;
								wlnk = rlnk;
							end
							cnt_d = '0;
							hit_d = '0;
							fsm_d = tts_pkg::FS_SCHED;
						end
					end
				endcase
			end
			tts_pkg::FS_V_LINK: begin
				// Block the current task (wait, P) or wake the wait-list head (V): read it, then write BLOCKED or READY.
				ra = idx_q;
				if (cnt_q == 4'd0) begin
					cnt_d = 4'd1;
				end else begin
					twe = 1'b1;
					twpar = 1'b1;
					twlnk = 1'b1;
					wa = idx_q;
					cnt_d = '0;
					if (rq_q.command == tts_pkg::CMD_V) begin
						wst = tts_pkg::ST_READY;
						wpar = rpar;
						wlnk = rlnk;
						swh = 1'b1;
						swhd = rlnk;
						fsm_d = tts_pkg::FS_OUT;
					end else begin
						wst = tts_pkg::ST_BLOCKED;
						wpar = rpar;
						wlnk = (rq_q.command == tts_pkg::CMD_P) ? shead : rlnk;
						if (rq_q.command == tts_pkg::CMD_P) begin
							swh = 1'b1;
							swhd = {1'b0, cur_q};
						end
						fsm_d = tts_pkg::FS_SCHED;
					end
				end
			end
			tts_pkg::FS_SEM_RD: begin
				fsm_d = tts_pkg::FS_SEM_OP;
				if (rq_q.command == tts_pkg::CMD_SGET) begin
					fsm_d = tts_pkg::FS_OUT;
				end
			end
			tts_pkg::FS_SEM_OP: begin
				swe = 1'b1;
				swv = snew;
				fsm_d = tts_pkg::FS_OUT;
				idx_d = cur_q;
				cnt_d = '0;
				if (rq_q.command == tts_pkg::CMD_P) begin
					if (snew < 0) fsm_d = tts_pkg::FS_V_LINK;
				end else if (snew <= 0 && shead < tts_pkg::LinkNull) begin
					idx_d = shead[3:0];
					fsm_d = tts_pkg::FS_V_LINK;
				end
			end
			tts_pkg::FS_SCHED: begin
				scur_d = cur_q;
				cnt_d = '0;
				if (live_q == 5'd0) begin
					ra = Kern;
					idx_d = Kern;
					cur_d = Kern;
					hit_d = 4'd2;
					fsm_d = tts_pkg::FS_SCHED_CHK;
				end else begin
					idx_d = (cur_q == Kern) ? 4'd0 : cur_q + 4'd1;
					ra = idx_d;
					hit_d = 4'd0;
					fsm_d = (cur_q == idx_d) ? tts_pkg::FS_OUT : tts_pkg::FS_SCHED_CHK;
				end
			end
			tts_pkg::FS_SCHED_CHK: begin
				ra = idx_q;
				if (hit_q == 4'd2) begin
					// Make the kernel slot RUNNING, keeping its parent and link.
					twe = 1'b1;
					twpar = 1'b1;
					twlnk = 1'b1;
					wa = Kern;
					wst = tts_pkg::ST_RUNNING;
					wpar = rpar;
					wlnk = rlnk;
					if (cnt_q == 4'd0) cnt_d = 4'd1;
					else fsm_d = tts_pkg::FS_OUT;
					twe = (cnt_q != 4'd0);
					twpar = (cnt_q != 4'd0);
					twlnk = (cnt_q != 4'd0);
				end else if (hit_q == 4'd1) begin
					// Demote old current if RUNNING; idx_q holds it.
					if (cnt_q == 4'd0) begin
						cnt_d = 4'd1;
					end else begin
						if (rst == tts_pkg::ST_RUNNING) begin
							twe = 1'b1;
							twpar = 1'b1;
							twlnk = 1'b1;
							wa = idx_q;
							wst = tts_pkg::ST_READY;
							wpar = rpar;
							wlnk = rlnk;
						end
						fsm_d = tts_pkg::FS_OUT;
					end
				end else if (cnt_q == 4'd0) begin
					cnt_d = 4'd1;
				end else if (rst == tts_pkg::ST_READY) begin
					twe = 1'b1;
					twpar = 1'b1;
					twlnk = 1'b1;
					wa = idx_q;
					wst = tts_pkg::ST_RUNNING;
					wpar = rpar;
					wlnk = rlnk;
					cur_d = idx_q;
					idx_d = scur_q;
					ra = scur_q;
					hit_d = 4'd1;
					cnt_d = '0;
				end else if (idx_nx == scur_q) begin
					fsm_d = tts_pkg::FS_OUT;
				end else begin
					idx_d = idx_nx;
					ra = idx_nx;
					cnt_d = '0;
				end
			end
			tts_pkg::FS_OUT: begin
				fsm_d = tts_pkg::FS_IDLE;
			end
			default: fsm_d = tts_pkg::FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= tts_pkg::FS_IDLE;
			cur_q <= Kern;
			live_q <= '0;
			inuse_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			scur_q <= '0;
			hit_q <= '0;
			status_q <= 1'b0;
			rid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			cur_q <= cur_d;
			live_q <= live_d;
			inuse_q <= inuse_d;
			idx_q <= idx_d;
			cnt_q <= cnt_d;
			scur_q <= scur_d;
			hit_q <= hit_d;
			status_q <= status_d;
			rid_q <= rid_d;
			if (fsm_q == tts_pkg::FS_OUT) rvalid_q <= 1'b1;
			else if (rsp.ready) rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) rq_q <= req.data;
		if (fsm_q == tts_pkg::FS_OUT) begin
			rdata_q.status <= status_q;
			rdata_q.result_id <= rid_q;
			rdata_q.running_task <= cur_q;
			rdata_q.live_tasks <= live_q;
		end
	end

	assign req.ready = (fsm_q == tts_pkg::FS_IDLE) && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.data = rdata_q;

`ifndef SYNTH
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == tts_pkg::FS_OUT) |=> rsp.valid)
		else $error("result not presented");
	a_live_max: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == tts_pkg::FS_IDLE) |-> (cur_q <= Kern))
		else $error("current task out of range");
`endif
endmodule

[verif/tb_task_table_scheduler_with_semaphores.sv]
// Testbench for task_table_scheduler_with_semaphores: directed and random kernel commands,
// checked field by field against a predictor of the task and semaphore tables.
// Depends on tts_pkg, tts_req_if, tts_rsp_if and the block under test.
module tb_task_table_scheduler_with_semaphores;
	import tts_pkg::*;

	localparam int NTASK = NumTasksDef;
	localparam int NSEM = NumSemsDef;
	localparam int KSLOT = NTASK - 1;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	tts_req_if req ();
	tts_rsp_if rsp ();

	task_table_scheduler_with_semaphores dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	tstate_t task_st[NTASK];
	logic [3:0] task_par[NTASK];
	logic [4:0] task_link[NTASK];
	logic [3:0] cur_task;
	int live_cnt;
	int sem_val[NSEM];
	bit sem_used[NSEM];
	bit sem_written[NSEM];
	logic [4:0] sem_head[NSEM];

	rsp_t pending_rsp[$];
	int errors;
	int cycles;
	int burst_left;
	int hold_cycles;
	rsp_t seen;
	rsp_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic reset_tables();
		for (int i = 0; i < NTASK; i++) begin
			task_st[i] = ST_NEW;
			task_par[i] = '0;
			task_link[i] = LinkNull;
		end
		task_st[KSLOT] = ST_RUNNING;
		task_par[KSLOT] = 4'(KSLOT);
		cur_task = 4'(KSLOT);
		live_cnt = 0;
		for (int s = 0; s < NSEM; s++) begin
			sem_val[s] = 0;
			sem_used[s] = 0;
			sem_written[s] = 0;
			sem_head[s] = LinkNull;
		end
	endtask

	task automatic round_robin();
		int c;
		int i;
		c = cur_task;
		i = (c + 1) % NTASK;
		if (live_cnt == 0) begin
			cur_task = 4'(KSLOT);
			task_st[KSLOT] = ST_RUNNING;
			return;
		end
		while (i != c) begin
			if (task_st[i] == ST_READY) begin
				if (task_st[c] == ST_RUNNING)
					task_st[c] = ST_READY;
				task_st[i] = ST_RUNNING;
				cur_task = 4'(i);
				return;
			end
			i = (i + 1) % NTASK;
		end
	endtask

	function automatic void live_down();
		if (live_cnt > 0)
			live_cnt--;
	endfunction

	task automatic predict_kernel_call(input req_t r, output rsp_t o);
		int c;
		int s;
		int i;
		int h;
		int p;
		o = '0;
		c = cur_task;
		s = r.sem_index;
		case (r.command)
			CMD_SCHED: round_robin();
			CMD_CREATE: begin
				for (i = 0; i < NTASK; i++)
					if (task_st[i] == ST_NEW)
						break;
				if (i == NTASK) begin
					o.status = 1'b1;
				end else begin
					task_par[i] = 4'(i);
					task_st[i] = ST_READY;
					if (live_cnt < 31)
						live_cnt++;
					o.result_id = 4'(i);
				end
			end
			CMD_END: begin
				live_down();
				task_st[c] = ST_END;
			end
			CMD_EXIT: begin
				p = task_par[c];
				if (task_st[p] == ST_BLOCKED)
					task_st[p] = ST_READY;
				task_st[c] = ST_NEW;
				live_down();
				round_robin();
			end
			CMD_WAIT: begin
				o.status = 1'b1;
				for (i = 0; i < NTASK; i++) begin
					if (task_st[i] != ST_NEW && task_par[i] == c && i != c) begin
						task_st[c] = ST_BLOCKED;
						o.status = 1'b0;
						round_robin();
						break;
					end
				end
			end
			CMD_SGET: begin
				o.status = 1'b1;
				for (i = 0; i < NSEM; i++) begin
					if (!sem_used[i]) begin
						sem_used[i] = 1;
						sem_written[i] = 1;
						sem_val[i] = r.init_count;
						o.result_id = 4'(i);
						o.status = 1'b0;
						break;
					end
				end
			end
			CMD_SFREE: begin
				if (s < NSEM)
					sem_used[s] = 0;
				else
					o.status = 1'b1;
			end
			CMD_P: begin
				if (s >= NSEM) begin
					o.status = 1'b1;
				end else begin
					if (sem_val[s] > -32768)
						sem_val[s]--;
					if (sem_val[s] < 0) begin
						task_st[c] = ST_BLOCKED;
						task_link[c] = sem_head[s];
						sem_head[s] = 5'(c);
						round_robin();
					end
				end
			end
			CMD_V: begin
				if (s >= NSEM) begin
					o.status = 1'b1;
				end else begin
					if (sem_val[s] < 32767)
						sem_val[s]++;
					if (sem_val[s] <= 0) begin
						h = sem_head[s];
						if (h < NTASK) begin
							sem_head[s] = task_link[h];
							task_st[h] = ST_READY;
						end
					end
				end
			end
			default: o.status = 1'b1;
		endcase
		o.running_task = cur_task;
		o.live_tasks = 5'(live_cnt);
	endtask

	task automatic send_request(input logic [3:0] cmd, input logic [3:0] sidx,
			input logic [15:0] init);
		int gap;
		req_t r;
		rsp_t o;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				req.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		r.command = cmd;
		r.sem_index = sidx;
		r.init_count = init;
		@(negedge clk);
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		predict_kernel_call(r, o);
		pending_rsp.push_back(o);
		burst_left--;
	endtask

	task automatic wait_all_done();
		@(negedge clk);
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_written_sem();
		int cand[$];
		for (int s = 0; s < NSEM; s++)
			if (sem_written[s])
				cand.push_back(s);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	task automatic send_random_command();
		int r;
		int s;
		r = $urandom_range(0, 99);
		if (r >= 78 && r < 98) begin
			s = pick_written_sem();
			if (s < 0)
				send_request(CMD_SGET, 4'($urandom), 16'($urandom));
			else
				send_request((r < 88) ? CMD_P : CMD_V, 4'(s), 16'($urandom));
		end else if (r < 20)
			send_request(CMD_SCHED, 4'($urandom), 16'($urandom));
		else if (r < 35)
			send_request(CMD_CREATE, 4'($urandom), 16'($urandom));
		else if (r < 40)
			send_request(CMD_END, 4'($urandom), 16'($urandom));
		else if (r < 55)
			send_request(CMD_EXIT, 4'($urandom), 16'($urandom));
		else if (r < 60)
			send_request(CMD_WAIT, 4'($urandom), 16'($urandom));
		else if (r < 70)
			send_request(CMD_SGET, 4'($urandom),
				($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
		else if (r < 78)
			send_request(CMD_SFREE, 4'($urandom), 16'($urandom));
		else
			send_request(4'($urandom_range(9, 15)), 4'($urandom), 16'($urandom));
	endtask

	task automatic test_directed();
		send_request(CMD_SCHED, 4'd0, 16'd0);
		send_request(CMD_WAIT, 4'd15, 16'hffff);
		for (int i = 0; i < NTASK; i++)
			send_request(CMD_CREATE, 4'(i), 16'h0);
		send_request(CMD_SCHED, 4'd0, 16'd0);
		send_request(CMD_SGET, 4'd0, 16'h7fff);
		send_request(CMD_SGET, 4'd0, 16'h8000);
		send_request(CMD_V, 4'd0, 16'd0);
		send_request(CMD_P, 4'd1, 16'd0);
		send_request(CMD_V, 4'd1, 16'd0);
		send_request(CMD_SFREE, 4'd1, 16'd0);
		send_request(4'd9, 4'd0, 16'd0);
		send_request(4'd15, 4'd15, 16'hffff);
		send_request(CMD_END, 4'd0, 16'd0);
		send_request(CMD_EXIT, 4'd0, 16'd0);
		wait_all_done();
	endtask

	task automatic test_random_traffic();
		repeat (1750)
			send_random_command();
		wait_all_done();
	endtask

	task automatic test_output_backpressure();
		hold_cycles = 300;
		repeat (60)
			send_random_command();
		wait_all_done();
	endtask

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else if ((cycles / 512) % 3 == 0) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			seen = rsp.data;
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_rsp.pop_front();
				if (seen.status !== want.status)
					report_mismatch($sformatf("status %0b, expected %0b",
						seen.status, want.status));
				if (seen.result_id !== want.result_id)
					report_mismatch($sformatf("result_id %0d, expected %0d",
						seen.result_id, want.result_id));
				if (seen.running_task !== want.running_task)
					report_mismatch($sformatf("running_task %0d, expected %0d",
						seen.running_task, want.running_task));
				if (seen.live_tasks !== want.live_tasks)
					report_mismatch($sformatf("live_tasks %0d, expected %0d",
						seen.live_tasks, want.live_tasks));
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		reset_tables();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_output_backpressure();
		test_random_traffic();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
